### rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
package u8dec_pkg;

    localparam int unsigned MAX_STRING_BYTES = 65536;
    localparam int unsigned POS_W            = 17;
    localparam int unsigned CP_W             = 21;
    localparam int unsigned POS_FIELD_MAX    = (1 << POS_W) - 1;
    localparam int unsigned POS_CAP_INT      = (MAX_STRING_BYTES < POS_FIELD_MAX) ?
                                               MAX_STRING_BYTES : POS_FIELD_MAX;
    localparam logic [POS_W-1:0] POS_CAP     = POS_CAP_INT[POS_W-1:0];

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_BADCONT = 2'd2,
        ST_BADLEAD = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic [POS_W-1:0] error_pos;
        logic             last_result;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       bytes_pending;
        logic [CP_W-1:0]  partial_value;
        logic [POS_W-1:0] byte_index;
        logic             discarding;
    } t_dec_state;

endpackage

### rtl/u8dec_step.sv
// Per-byte decode logic: next decoder state and the optional result word.
module u8dec_step import u8dec_pkg::*; (
    input  t_dec_state i_state,
    input  t_in_item   i_item,
    output t_dec_state o_state,
    output logic       o_res_valid,
    output t_out_item  o_res
);

    logic [7:0]       b;
    logic             eos;
    logic [POS_W-1:0] pos_inc;
    logic             err;
    t_status          err_st;
    logic [POS_W-1:0] err_pos;
    t_dec_state       nxt;

    assign b   = i_item.byte_in;
    assign eos = i_item.end_of_string;
    assign pos_inc = (i_state.byte_index >= POS_CAP) ? POS_CAP
                                                     : i_state.byte_index + 1'b1;

    always_comb begin
        nxt         = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        err         = 1'b0;
        err_st      = ST_OK;
        err_pos     = i_state.byte_index;
        o_state     = i_state;

        if (i_state.discarding) begin
            if (eos) begin
                o_state = '0;
            end else begin
                o_state.byte_index = pos_inc;
            end
        end else begin
            if (i_state.bytes_pending == 2'd0) begin
                if (!b[7]) begin
                    o_res_valid       = 1'b1;
                    o_res.code_point  = {{(CP_W-8){1'b0}}, b};
                    o_res.status      = ST_OK;
                    o_res.last_result = eos;
                end else if (b[7:5] == 3'b110) begin
                    nxt.partial_value = {{(CP_W-5){1'b0}}, b[4:0]};
                    nxt.bytes_pending = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    nxt.partial_value = {{(CP_W-4){1'b0}}, b[3:0]};
                    nxt.bytes_pending = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    nxt.partial_value = {{(CP_W-3){1'b0}}, b[2:0]};
                    nxt.bytes_pending = 2'd3;
                end else begin
                    err    = 1'b1;
                    err_st = ST_BADLEAD;
                end
            end else if (b[7:6] != 2'b10) begin
                err    = 1'b1;
                err_st = ST_BADCONT;
            end else begin
                nxt.partial_value = {i_state.partial_value[CP_W-7:0], b[5:0]};
                nxt.bytes_pending = i_state.bytes_pending - 2'd1;
                if (nxt.bytes_pending == 2'd0) begin
                    o_res_valid       = 1'b1;
                    o_res.code_point  = nxt.partial_value;
                    o_res.status      = ST_OK;
                    o_res.last_result = eos;
                    nxt.partial_value = '0;
                end
            end

            // string ends with a sequence still open
            if (!err && eos && nxt.bytes_pending != 2'd0) begin
                err     = 1'b1;
                err_st  = ST_TRUNC;
                err_pos = pos_inc;
            end

            if (err) begin
                o_res_valid       = 1'b1;
                o_res.code_point  = '0;
                o_res.status      = err_st;
                o_res.error_pos   = err_pos;
                o_res.last_result = 1'b1;
                o_state           = '0;
                if (!eos) begin
                    o_state.discarding = 1'b1;
                    o_state.byte_index = pos_inc;
                end
            end else if (eos) begin
                o_state = '0;
            end else begin
                o_state            = nxt;
                o_state.byte_index = pos_inc;
            end
        end
    end

endmodule

### rtl/utf8_byte_stream_decoder.sv
// Top level of the streaming UTF-8 decoder: input stage, state and result register.
//
// Input channel (i_valid / o_ready / i_data) carries one byte of an encoded
// string per word, with end_of_string set on the final byte. Output channel
// (o_valid / i_ready / o_data) carries one result word per completed code
// point or per error; bytes inside a sequence and discarded bytes give none.
// Errors (bad lead, bad continuation, truncation) are reported once with
// their byte position and last_result set; the rest of the string is dropped.
// Throughput: one byte per cycle while the output is not stalled. An accepted
// byte is held in the input register and its result in the result register.
// The path is one input register, the decode logic and one result register.
// While the receiver stalls, the input register still takes one more byte,
// and bytes that give no result keep flowing through. o_ready falls only
// when the input register holds a byte with a result and the result
// register is full and not being taken.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to the start of a string.
module utf8_byte_stream_decoder import u8dec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic       r_in_valid, n_in_valid;
    t_in_item   r_in, n_in;
    t_dec_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    t_dec_state step_state;
    logic       step_res_valid;
    t_out_item  step_res;
    logic       advance;

    u8dec_step u_step (
        .i_state    (r_state),
        .i_item     (r_in),
        .o_state    (step_state),
        .o_res_valid(step_res_valid),
        .o_res      (step_res)
    );

    assign advance = r_in_valid && (!step_res_valid || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_state    = step_state;
            n_in_valid = 1'b0;
            if (step_res_valid) begin
                n_out_valid = 1'b1;
                n_out       = step_res;
            end
        end
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
            n_in       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

endmodule

### rtl/u8dec_chk.sv
// Port-level checks on the UTF-8 decoder and their bind to the top level.
module u8dec_chk import u8dec_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // result register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.last_result && o_data.code_point == '0)
        else $error("error word without last flag or with nonzero code point");

    a_ok_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_OK |-> o_data.error_pos == '0)
        else $error("ok word carries an error position");

    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.error_pos <= POS_CAP)
        else $error("error position beyond saturation limit");

endmodule

bind utf8_byte_stream_decoder u8dec_chk u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
